// ===== rtl/q2e_pkg.sv =====
// ----------------------------------------------------------------------------
// q2e_pkg: shared types and constants for the quaternion to Euler core
// Widths, CORDIC angle table and per-step helper functions.
// ----------------------------------------------------------------------------
package q2e_pkg;

  // number format of the quaternion components and results
  localparam int QW           = 16;
  localparam int PW           = 32;  // one component product
  localparam int SW           = 34;  // doubled sums at Q.30
  localparam int CW           = 36;  // CORDIC x / y datapath
  localparam int ZW           = 27;  // CORDIC angle, degrees * 2^16
  localparam int ZW1          = ZW + 1;
  localparam int MW           = 30;  // |sinp| below one
  localparam int SQW          = 2 * MW;
  localparam int VW           = 62;  // radicand, padded to whole bit pairs
  localparam int RTW          = VW / 2;  // square root width
  localparam int RMW          = RTW + 2; // square root remainder
  localparam int SQN          = VW / 2;  // square root steps

  localparam int CORDIC_STEPS = 16;
  localparam int ANG_LEN      = 24;
  localparam int NSTEP        = (CORDIC_STEPS > ANG_LEN) ? ANG_LEN : CORDIC_STEPS;

  localparam int ROLL_LIMIT   = 23040;
  localparam int PITCH_LIMIT  = 11520;

  localparam logic signed [SW-1:0] ONE_Q30    = SW'(64'sd1 <<< 30);
  localparam logic signed [ZW-1:0] DEG180_Q16 = ZW'(180 * 65536);

  // CORDIC working set for one angle
  typedef struct packed {
    logic signed [CW-1:0] x;
    logic signed [CW-1:0] y;
    logic signed [ZW-1:0] z;
    logic                 zero;
  } cord_t;

  // sine / cosine terms that ride along the square root stages
  typedef struct packed {
    logic signed [SW-1:0] sr;
    logic signed [SW-1:0] cr;
    logic signed [SW-1:0] sp;
    logic signed [SW-1:0] sy;
    logic signed [SW-1:0] cy;
    logic                 clamp;
    logic                 neg;
  } ang_t;

  // atan(2^-i) in degrees * 2^16
  function automatic logic signed [ZW-1:0] atan_ent(input int i);
    logic signed [ZW-1:0] v;
    case (i)
      0:  v = ZW'(2949120);
      1:  v = ZW'(1740967);
      2:  v = ZW'(919879);
      3:  v = ZW'(466945);
      4:  v = ZW'(234379);
      5:  v = ZW'(117304);
      6:  v = ZW'(58666);
      7:  v = ZW'(29335);
      8:  v = ZW'(14668);
      9:  v = ZW'(7334);
      10: v = ZW'(3667);
      11: v = ZW'(1833);
      12: v = ZW'(917);
      13: v = ZW'(458);
      14: v = ZW'(229);
      15: v = ZW'(115);
      16: v = ZW'(57);
      17: v = ZW'(29);
      18: v = ZW'(14);
      19: v = ZW'(7);
      20: v = ZW'(4);
      21: v = ZW'(2);
      22: v = ZW'(1);
      default: v = '0;
    endcase
    return v;
  endfunction

  // fold the left half plane onto the right one, flag the origin
  function automatic cord_t cordic_pre(input logic signed [SW-1:0] sy_in,
                                       input logic signed [SW-1:0] sx_in);
    cord_t c;
    c.zero = (sx_in == '0) && (sy_in == '0);
    c.x    = CW'(sx_in);
    c.y    = CW'(sy_in);
    c.z    = '0;
    if (sx_in < 0) begin
      c.z = (sy_in >= 0) ? DEG180_Q16 : -DEG180_Q16;
      c.x = -c.x;
      c.y = -c.y;
    end
    return c;
  endfunction

  // one vectoring rotation
  function automatic cord_t cordic_iter(input cord_t c, input int i);
    cord_t                r;
    logic signed [CW-1:0] xv;
    logic signed [CW-1:0] yv;
    logic signed [CW-1:0] dx;
    logic signed [CW-1:0] dy;
    xv = c.x;
    yv = c.y;
    dx = yv >>> i;
    dy = xv >>> i;
    r  = c;
    if (yv > 0) begin
      r.x = xv + dx;
      r.y = yv - dy;
      r.z = c.z + atan_ent(i);
    end else begin
      r.x = xv - dx;
      r.y = yv + dy;
      r.z = c.z - atan_ent(i);
    end
    return r;
  endfunction

  // round half up to 1/128 degree and saturate
  function automatic logic signed [QW-1:0] round_clamp(input logic signed [ZW-1:0] z,
                                                       input logic zero,
                                                       input int limit);
    logic signed [ZW1-1:0] t;
    logic signed [ZW1-1:0] r;
    logic signed [ZW1-1:0] lim;
    lim = ZW1'(limit);
    t   = ZW1'(z) + ZW1'(256);
    r   = t >>> 9;
    if (zero) begin
      r = '0;
    end else if (r > lim) begin
      r = lim;
    end else if (r < -lim) begin
      r = -lim;
    end
    return QW'(r);
  endfunction

endpackage

// ===== rtl/quaternion_to_euler_angles_core.sv =====
// ----------------------------------------------------------------------------
// quaternion_to_euler_angles_core: attitude quaternion to roll/pitch/yaw
// Fully pipelined; one quaternion per clock while the output is not held, results in 1/128 degree.
// ----------------------------------------------------------------------------
// Accepts one Q1.15 quaternion every clock and returns roll, pitch and yaw.
// The pipeline depth is set by the pitch path: four stages of products,
// sums, squaring and the radicand, 31 square-root stages that build
// cos(pitch) one bit per stage, then a CORDIC pre-rotation, one stage per
// CORDIC iteration shared in form by all three angles, and a rounding stage.
// When the output is held by tready low the whole pipeline freezes and
// s_axis_tready drops; nothing is lost or repeated. pitch_clamped (tuser) is
// high when |2(wy-zx)| reached one and pitch was saturated to +-90 degrees.
module quaternion_to_euler_angles_core (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [63:0] s_axis_tdata,   // quat_w, quat_x, quat_y, quat_z
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [47:0] m_axis_tdata,   // roll_deg, pitch_deg, yaw_deg, 1'b0
  output logic        m_axis_tuser    // pitch_clamped
);
  import q2e_pkg::*;

  logic ce;

  // input fields
  logic signed [QW-1:0] qw, qx, qy, qz;

  // stage 1: products
  logic signed [PW-1:0] wx, yz, xx, yy, wy, zx, wz, xy, zz;
  logic                 v1;

  // stage 2: doubled sums
  ang_t                 a2;
  logic [MW-1:0]        mag2;
  logic                 v2;

  // stage 3: sinp squared
  ang_t                 a3;
  logic [SQW-1:0]       sq3;
  logic                 v3;

  // square root stages
  ang_t                 sq_a [0:SQN];
  logic                 sq_v [0:SQN];
  logic [VW-1:0]        sq_vr[0:SQN];
  logic [RMW-1:0]       rem  [1:SQN];
  logic [RTW-1:0]       root [1:SQN];

  // CORDIC stages
  cord_t                c_roll [0:NSTEP];
  cord_t                c_pit  [0:NSTEP];
  cord_t                c_yaw  [0:NSTEP];
  logic                 c_clamp[0:NSTEP];
  logic                 c_neg  [0:NSTEP];
  logic                 c_v    [0:NSTEP];

  // output register
  logic signed [QW-1:0]   roll_o;
  logic signed [QW-2:0]   pitch_o;
  logic signed [QW-1:0]   yaw_o;
  logic                   clamp_o;
  logic                   out_v;

  ang_t                 a2_next;
  logic signed [SW-1:0] sp_n;

  // advance everything unless a result is held at the output
  assign ce            = !out_v || m_axis_tready;
  assign s_axis_tready = ce;

  assign qw = s_axis_tdata[15:0];
  assign qx = s_axis_tdata[31:16];
  assign qy = s_axis_tdata[47:32];
  assign qz = s_axis_tdata[63:48];

  // stage 1: all component products
  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (ce) begin
      v1 <= s_axis_tvalid;
    end
    if (ce) begin
      wx <= qw * qx;
      yz <= qy * qz;
      xx <= qx * qx;
      yy <= qy * qy;
      wy <= qw * qy;
      zx <= qz * qx;
      wz <= qw * qz;
      xy <= qx * qy;
      zz <= qz * qz;
    end
  end

  // stage 2: sine and cosine terms at Q.30
  always_comb begin
    sp_n        = (SW'(wy) - SW'(zx)) <<< 1;
    a2_next.sr  = (SW'(wx) + SW'(yz)) <<< 1;
    a2_next.cr  = ONE_Q30 - ((SW'(xx) + SW'(yy)) <<< 1);
    a2_next.sp  = sp_n;
    a2_next.sy  = (SW'(wz) + SW'(xy)) <<< 1;
    a2_next.cy  = ONE_Q30 - ((SW'(yy) + SW'(zz)) <<< 1);
    a2_next.clamp = (sp_n >= ONE_Q30) || (sp_n <= -ONE_Q30);
    a2_next.neg = sp_n < 0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else if (ce) begin
      v2 <= v1;
    end
    if (ce) begin
      a2   <= a2_next;
      mag2 <= MW'(a2_next.neg ? -sp_n : sp_n);
    end
  end

  // stage 3: square sinp
  always_ff @(posedge clk) begin
    if (rst) begin
      v3 <= 1'b0;
    end else if (ce) begin
      v3 <= v2;
    end
    if (ce) begin
      a3  <= a2;
      sq3 <= mag2 * mag2;
    end
  end

  // radicand 1 - sinp^2 at Q.60
  always_ff @(posedge clk) begin
    if (rst) begin
      sq_v[0] <= 1'b0;
    end else if (ce) begin
      sq_v[0] <= v3;
    end
    if (ce) begin
      sq_a[0]  <= a3;
      sq_vr[0] <= (VW'(1) << 60) - VW'(sq3);
    end
  end

  // square root, one result bit per stage
  for (genvar k = 0; k < SQN; k++) begin : g_sqrt
    logic [RMW-1:0] rem_i;
    logic [RTW-1:0] root_i;
    logic [RMW+1:0] tmp;
    logic [RMW+1:0] trial;

    if (k == 0) begin : g_first
      assign rem_i  = '0;
      assign root_i = '0;
    end else begin : g_rest
      assign rem_i  = rem[k];
      assign root_i = root[k];
    end

    assign tmp   = {rem_i, sq_vr[k][VW-1-2*k -: 2]};
    assign trial = (RMW+2)'({root_i, 2'b01});

    always_ff @(posedge clk) begin
      if (rst) begin
        sq_v[k+1] <= 1'b0;
      end else if (ce) begin
        sq_v[k+1] <= sq_v[k];
      end
      if (ce) begin
        sq_a[k+1]  <= sq_a[k];
        sq_vr[k+1] <= sq_vr[k];
        if (tmp >= trial) begin
          rem[k+1]  <= RMW'(tmp - trial);
          root[k+1] <= {root_i[RTW-2:0], 1'b1};
        end else begin
          rem[k+1]  <= RMW'(tmp);
          root[k+1] <= {root_i[RTW-2:0], 1'b0};
        end
      end
    end
  end

  // CORDIC pre-rotation for the three angles
  always_ff @(posedge clk) begin
    if (rst) begin
      c_v[0] <= 1'b0;
    end else if (ce) begin
      c_v[0] <= sq_v[SQN];
    end
    if (ce) begin
      c_roll[0]  <= cordic_pre(sq_a[SQN].sr, sq_a[SQN].cr);
      c_yaw[0]   <= cordic_pre(sq_a[SQN].sy, sq_a[SQN].cy);
      c_pit[0]   <= cordic_pre(sq_a[SQN].sp, SW'($signed({1'b0, root[SQN]})));
      c_clamp[0] <= sq_a[SQN].clamp;
      c_neg[0]   <= sq_a[SQN].neg;
    end
  end

  // CORDIC iterations, one per stage
  for (genvar j = 0; j < NSTEP; j++) begin : g_cordic
    always_ff @(posedge clk) begin
      if (rst) begin
        c_v[j+1] <= 1'b0;
      end else if (ce) begin
        c_v[j+1] <= c_v[j];
      end
      if (ce) begin
        c_roll[j+1]  <= cordic_iter(c_roll[j], j);
        c_yaw[j+1]   <= cordic_iter(c_yaw[j], j);
        c_pit[j+1]   <= cordic_iter(c_pit[j], j);
        c_clamp[j+1] <= c_clamp[j];
        c_neg[j+1]   <= c_neg[j];
      end
    end
  end

  // round, saturate and hold the result
  always_ff @(posedge clk) begin
    if (rst) begin
      out_v <= 1'b0;
    end else if (ce) begin
      out_v <= c_v[NSTEP];
    end
    if (ce) begin
      roll_o  <= round_clamp(c_roll[NSTEP].z, c_roll[NSTEP].zero, ROLL_LIMIT);
      yaw_o   <= round_clamp(c_yaw[NSTEP].z, c_yaw[NSTEP].zero, ROLL_LIMIT);
      clamp_o <= c_clamp[NSTEP];
      if (c_clamp[NSTEP]) begin
        pitch_o <= c_neg[NSTEP] ? -(QW-1)'(PITCH_LIMIT) : (QW-1)'(PITCH_LIMIT);
      end else begin
        pitch_o <= (QW-1)'(round_clamp(c_pit[NSTEP].z, c_pit[NSTEP].zero, PITCH_LIMIT));
      end
    end
  end

  assign m_axis_tvalid = out_v;
  assign m_axis_tdata  = {1'b0, yaw_o, pitch_o, roll_o};
  assign m_axis_tuser  = clamp_o;

endmodule

// ===== rtl/q2e_checker.sv =====
// ----------------------------------------------------------------------------
// q2e_checker: port-level checks for the quaternion to Euler core
// Watches the stream ports over time; bound to the top level.
// ----------------------------------------------------------------------------
module q2e_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic [63:0] s_axis_tdata,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [47:0] m_axis_tdata,
  input logic        m_axis_tuser
);
  import q2e_pkg::*;

  logic signed [15:0] roll_v;
  logic signed [14:0] pitch_v;
  logic signed [15:0] yaw_v;

  assign roll_v  = m_axis_tdata[15:0];
  assign pitch_v = m_axis_tdata[30:16];
  assign yaw_v   = m_axis_tdata[46:31];

  // hold a stalled output transaction
  a_hold_valid: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
    else $error("output transaction dropped while stalled");

  a_hold_data: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata) && $stable(m_axis_tuser))
    else $error("output transaction changed while stalled");

  // input stalls only behind a held result
  a_back_pressure: assert property (@(posedge clk) disable iff (rst)
    !s_axis_tready |-> m_axis_tvalid && !m_axis_tready)
    else $error("input stalled without output back pressure");

  // a clamped pitch sits exactly on +-90 degrees
  a_clamp_value: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tuser |->
      (pitch_v == 15'(PITCH_LIMIT)) || (pitch_v == -15'(PITCH_LIMIT)))
    else $error("clamped pitch not at the limit");

  // angles stay within range
  a_range: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> (roll_v <= 16'(ROLL_LIMIT)) && (roll_v >= -16'(ROLL_LIMIT)) &&
                      (yaw_v <= 16'(ROLL_LIMIT)) && (yaw_v >= -16'(ROLL_LIMIT)) &&
                      (pitch_v <= 15'(PITCH_LIMIT)) && (pitch_v >= -15'(PITCH_LIMIT)))
    else $error("output angle out of range");

endmodule

bind quaternion_to_euler_angles_core q2e_checker u_q2e_checker (.*);

// ===== bench/q2e_checker.sv =====
// ----------------------------------------------------------------------------
// q2e_scoreboard: scoreboard for the quaternion to Euler core
// Watches both stream channels, computes roll, pitch and yaw for every
// accepted quaternion and compares each returned transaction in order.
// ----------------------------------------------------------------------------
module q2e_scoreboard (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  input  logic        s_axis_tready,
  input  logic [63:0] s_axis_tdata,   // quat_w, quat_x, quat_y, quat_z
  input  logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  input  logic [47:0] m_axis_tdata,   // roll_deg, pitch_deg, yaw_deg, 1'b0
  input  logic        m_axis_tuser,   // pitch_clamped
  output int          fail_count,
  output int          pending
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic signed [15:0] roll;
    logic signed [14:0] pitch;
    logic signed [15:0] yaw;
    logic               clamped;
  } euler_t;

  localparam int STEPS = (q2e_pkg::CORDIC_STEPS > 24) ? 24 : q2e_pkg::CORDIC_STEPS;
  localparam longint ONE = 64'sd1 <<< 30;

  euler_t angle_queue[$];

  function automatic longint atan_deg(input int i);
    longint tbl[24] = '{2949120, 1740967, 919879, 466945, 234379, 117304, 58666,
                        29335, 14668, 7334, 3667, 1833, 917, 458, 229, 115,
                        57, 29, 14, 7, 4, 2, 1, 0};
    return tbl[i];
  endfunction

  // vectoring arctangent, degrees * 2^16
  function automatic longint vec_atan2(input longint y, input longint x);
    longint ang, dx, dy;
    ang = 0;
    if (x == 0 && y == 0) return 0;
    if (x < 0) begin
      ang = (y >= 0) ? 180 * 65536 : -180 * 65536;
      x = -x;
      y = -y;
    end
    for (int i = 0; i < STEPS; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (y > 0) begin
        x += dx; y -= dy; ang += atan_deg(i);
      end else begin
        x -= dx; y += dy; ang -= atan_deg(i);
      end
    end
    return ang;
  endfunction

  function automatic longint round_deg(input longint ang, input longint lim);
    longint r;
    r = (ang + 256) >>> 9;
    if (r > lim) r = lim;
    if (r < -lim) r = -lim;
    return r;
  endfunction

  function automatic longint int_sqrt(input longint unsigned v);
    longint unsigned r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > v) b >>= 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v -= r + b;
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return r;
  endfunction

  function automatic euler_t predict_euler(input logic [63:0] q);
    euler_t e;
    longint w, x, y, z, sr, cr, sp, sy, cy, mag;
    w = longint'($signed(q[15:0]));
    x = longint'($signed(q[31:16]));
    y = longint'($signed(q[47:32]));
    z = longint'($signed(q[63:48]));
    sr = 2 * (w * x + y * z);
    cr = ONE - 2 * (x * x + y * y);
    sp = 2 * (w * y - z * x);
    sy = 2 * (w * z + x * y);
    cy = ONE - 2 * (y * y + z * z);
    e.roll = 16'(round_deg(vec_atan2(sr, cr), 23040));
    e.yaw  = 16'(round_deg(vec_atan2(sy, cy), 23040));
    e.clamped = 1'b0;
    if (sp >= ONE) begin
      e.pitch = 15'(11520); e.clamped = 1'b1;
    end else if (sp <= -ONE) begin
      e.pitch = -15'sd11520; e.clamped = 1'b1;
    end else begin
      mag = (sp < 0) ? -sp : sp;
      e.pitch = 15'(round_deg(vec_atan2(sp, int_sqrt((64'd1 << 60) - mag * mag)), 11520));
    end
    return e;
  endfunction

  task automatic report_mismatch(input string what, input longint got, input longint want);
    $display("mismatch %s: got %0d expected %0d", what, got, want);
    fail_count++;
  endtask

  assign pending = angle_queue.size();

  // predict on input transactions, compare on output transactions
  always @(posedge clk) begin
    euler_t want;
    if (rst) begin
      angle_queue.delete();
      fail_count = 0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) angle_queue.push_back(predict_euler(s_axis_tdata));
      if (m_axis_tvalid && m_axis_tready) begin
        if (angle_queue.size() == 0) begin
          report_mismatch("unexpected transaction", 0, 0);
        end else begin
          want = angle_queue.pop_front();
          if ($signed(m_axis_tdata[15:0]) != want.roll)
            report_mismatch("roll", $signed(m_axis_tdata[15:0]), want.roll);
          if ($signed(m_axis_tdata[30:16]) != want.pitch)
            report_mismatch("pitch", $signed(m_axis_tdata[30:16]), want.pitch);
          if ($signed(m_axis_tdata[46:31]) != want.yaw)
            report_mismatch("yaw", $signed(m_axis_tdata[46:31]), want.yaw);
          if (m_axis_tuser != want.clamped)
            report_mismatch("pitch_clamped", m_axis_tuser, want.clamped);
        end
      end
    end
  end
endmodule

// ===== bench/tb.sv =====
// ----------------------------------------------------------------------------
// tb: regression for the quaternion to Euler core
// Drives directed corner quaternions, then random unit-like and raw ones,
// with random gaps on both sides; the scoreboard scores every result.
// ----------------------------------------------------------------------------
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int LATENCY = 37 + q2e_pkg::CORDIC_STEPS;

  logic        clk;
  logic        rst;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [63:0] s_axis_tdata;   // quat_w, quat_x, quat_y, quat_z
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [47:0] m_axis_tdata;   // roll_deg, pitch_deg, yaw_deg, 1'b0
  logic        m_axis_tuser;   // pitch_clamped
  int          fail_count;
  int          pending;

  quaternion_to_euler_angles_core u_dut (.*);
  q2e_scoreboard u_chk (.*);

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #20ms;
    $display("[FAIL] regression broken");
    $finish;
  end

  // random output stalls
  initial begin
    int gap;
    m_axis_tready = 1'b0;
    @(posedge clk iff !rst);
    forever begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 12);
      if (gap != 0) begin
        m_axis_tready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      m_axis_tready <= 1'b1;
      @(posedge clk iff m_axis_tvalid);
    end
  end

  // present one quaternion and hold it until accepted
  task automatic send_quat(input logic [15:0] w, x, y, z, input bit gaps);
    int gap;
    gap = gaps ? $urandom_range(0, 12) : 0;
    if (gap != 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {z, y, x, w};
    @(posedge clk iff s_axis_tready);
  endtask

  // near-unit quaternion with random direction
  task automatic send_unit(input bit gaps);
    logic signed [15:0] c[4];
    int k;
    k = $urandom_range(0, 3);
    for (int i = 0; i < 4; i++) c[i] = $signed(16'($urandom_range(0, 32767))) >>> 1;
    c[k] = ($urandom_range(0, 1) ? 16'sd23170 : -16'sd23170) + 16'($urandom_range(0, 511));
    send_quat(c[0], c[1], c[2], c[3], gaps);
  endtask

  initial begin
    logic [15:0] edges[6] = '{16'h8000, 16'h7fff, 16'h0000, 16'hffff, 16'h5a82, 16'ha57e};
    rst = 1'b1;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    // identity, zero, extremes, gimbal lock both signs, pure axes
    send_quat(16'h7fff, 16'h0000, 16'h0000, 16'h0000, 1'b0);
    send_quat(16'h0000, 16'h0000, 16'h0000, 16'h0000, 1'b0);
    send_quat(16'h8000, 16'h8000, 16'h8000, 16'h8000, 1'b0);
    send_quat(16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff, 1'b0);
    send_quat(16'h5a82, 16'h0000, 16'h5a82, 16'h0000, 1'b1);
    send_quat(16'h5a82, 16'h0000, 16'ha57e, 16'h0000, 1'b1);
    send_quat(16'h4000, 16'h4000, 16'h4000, 16'hc000, 1'b1);
    send_quat(16'h0000, 16'h7fff, 16'h0000, 16'h0000, 1'b0);
    send_quat(16'h0000, 16'h0000, 16'h7fff, 16'h0000, 1'b0);
    send_quat(16'h0000, 16'h0000, 16'h0000, 16'h7fff, 1'b0);
    send_quat(16'h0000, 16'h8000, 16'h0000, 16'h0000, 1'b1);
    for (int i = 0; i < 12; i++)
      send_quat(edges[$urandom_range(0, 5)], edges[$urandom_range(0, 5)],
                edges[$urandom_range(0, 5)], edges[$urandom_range(0, 5)], i[0]);
    // drain fully before the random part
    s_axis_tvalid <= 1'b0;
    @(posedge clk iff pending == 0);
    for (int n = 0; n < 750; n++) begin
      if ($urandom_range(0, 3) == 0)
        send_quat(16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom), n[5]);
      else
        send_unit(n[5]);
    end
    s_axis_tvalid <= 1'b0;
    @(posedge clk iff pending == 0);
    repeat (LATENCY + 10) @(posedge clk);
    if (fail_count == 0)
      $display("[ OK ] regression clean");
    else
      $display("[FAIL] regression broken");
    $finish;
  end
endmodule
